// File: src/tce_pkg.sv
package tce_pkg;

	localparam int ROWS_DEF    = 25;
	localparam int COLUMNS_DEF = 80;

	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 4;
	localparam int ATTR_W   = 8;
	localparam int CELL_W   = 16;
	localparam int IDX_W    = 11;
	localparam int REQ_W    = 2;
	localparam int COL_O_W  = 7;
	localparam int ROW_O_W  = 5;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = REQ_W;
	localparam int M_TDATA_W = 32;

	localparam int CH_LSB  = 0;
	localparam int FG_LSB  = CH_LSB + CHAR_W;
	localparam int BG_LSB  = FG_LSB + COLOR_W;
	localparam int IDX_LSB = BG_LSB + COLOR_W;

	localparam int RD_LSB  = 0;
	localparam int COL_LSB = RD_LSB + CELL_W;
	localparam int ROW_LSB = COL_LSB + COL_O_W;
	localparam int M_USED  = ROW_LSB + ROW_O_W;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

	typedef enum logic [REQ_W-1:0] {
		OP_PUT   = 2'd0,
		OP_COLOR = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              newline;
		logic [CHAR_W-1:0] ch;
		logic [ATTR_W-1:0] attr;
		logic              oob;
	} cmd_t;

endpackage

// File: src/text_mode_console_engine.sv
// Text console engine: a ROWS x COLUMNS grid of 16-bit cells (attribute in the
// high byte, character in the low byte), a cursor and a current attribute.
// Requests enter on the s_ stream, one response per request leaves on the m_
// stream: read data (zero except for a read) and the cursor after the request.
// Requests pass a two-entry queue, so the input keeps taking transfers while the
// executor works or a response waits on a stalled m_tready; the response sits
// in an output register until taken, and the executor holds in the meantime.
// Work per request: a read fetches one cell; an ordinary character writes one
// cell; a newline writes spaces from the cursor to the end of its row; clear
// blanks every cell; set colour rewrites the attribute of every cell; a put that
// passes the last row also scrolls the grid up one row and blanks the bottom row.
// The cell RAM has one write port, so every grid-wide walk moves one cell per
// cycle; that port sets the worst-case time per request.
// After arst_n deasserts, a clearing pass fills every cell with a grey space;
// s_tready stays low until done.
module text_mode_console_engine #(
	parameter int ROWS    = tce_pkg::ROWS_DEF,
	parameter int COLUMNS = tce_pkg::COLUMNS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// char_code[7:0], foreground[11:8], background[15:12], cell_index[26:16]
	input  logic [tce_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type[1:0]
	input  logic [tce_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// read_data[15:0], cursor_col[22:16], cursor_row[27:23]
	output logic [tce_pkg::M_TDATA_W-1:0] m_tdata
);
	import tce_pkg::*;

	localparam int AW = $clog2(ROWS * COLUMNS);

	logic               hold;
	logic               cmd_valid;
	cmd_t               cmd;
	logic [AW-1:0]      cmd_addr;
	logic               cmd_pop;
	logic [CELL_W-1:0]  res_data;
	logic [COL_O_W-1:0] res_col;
	logic [ROW_O_W-1:0] res_row;

	tce_front #(
		.ROWS   (ROWS),
		.COLUMNS(COLUMNS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.hold     (hold),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_addr (cmd_addr),
		.cmd_pop  (cmd_pop)
	);

	tce_back #(
		.ROWS   (ROWS),
		.COLUMNS(COLUMNS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.hold     (hold),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_addr (cmd_addr),
		.cmd_pop  (cmd_pop),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res_data (res_data),
		.res_col  (res_col),
		.res_row  (res_row)
	);

	assign m_tdata = {(M_TDATA_W - M_USED)'(0), res_row, res_col, res_data};

endmodule

// File: src/tce_ram.sv
module tce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/tce_front.sv
module tce_front #(
	parameter int ROWS    = tce_pkg::ROWS_DEF,
	parameter int COLUMNS = tce_pkg::COLUMNS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [tce_pkg::S_TDATA_W-1:0]        s_tdata,
	input  logic [tce_pkg::S_TUSER_W-1:0]        s_tuser,
	input  logic                                 hold,
	output logic                                 cmd_valid,
	output tce_pkg::cmd_t                        cmd,
	output logic [$clog2(ROWS*COLUMNS)-1:0]      cmd_addr,
	input  logic                                 cmd_pop
);
	import tce_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int QD    = 2;
	localparam int PW    = $clog2(QD);

	cmd_t          fifo_q [QD];
	logic [AW-1:0] addr_q [QD];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;

	cmd_t          in_cmd;
	logic [AW-1:0] in_addr;
	logic [31:0]   idx_ext;
	logic [CHAR_W-1:0] ch;
	logic          push;

	assign ch       = s_tdata[CH_LSB +: CHAR_W];
	assign idx_ext  = 32'(s_tdata[IDX_LSB +: IDX_W]);

	always_comb begin
		in_cmd.op      = op_t'(s_tuser);
		in_cmd.newline = (ch == NEWLINE_CODE);
		in_cmd.ch      = ch;
		in_cmd.attr    = {s_tdata[BG_LSB +: COLOR_W], s_tdata[FG_LSB +: COLOR_W]};
		in_cmd.oob     = (idx_ext >= CELLS);
		in_addr        = in_cmd.oob ? '0 : idx_ext[AW-1:0];
	end

	assign s_tready  = (cnt_q != (PW+1)'(QD)) && !hold;
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign cmd_addr  = addr_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
			addr_q[wr_ptr_q] <= in_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/tce_back.sv
module tce_back #(
	parameter int ROWS    = tce_pkg::ROWS_DEF,
	parameter int COLUMNS = tce_pkg::COLUMNS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	output logic                                 hold,
	input  logic                                 cmd_valid,
	input  tce_pkg::cmd_t                        cmd,
	input  logic [$clog2(ROWS*COLUMNS)-1:0]      cmd_addr,
	output logic                                 cmd_pop,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic [tce_pkg::CELL_W-1:0]           res_data,
	output logic [tce_pkg::COL_O_W-1:0]          res_col,
	output logic [tce_pkg::ROW_O_W-1:0]          res_row
);
	import tce_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam logic [AW-1:0] LAST_A  = AW'(CELLS - 1);
	localparam logic [AW-1:0] BOTTOM  = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] ROW_OFS = AW'(COLUMNS);
	localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PUT   = 7'b0000010,
		ST_COPY  = 7'b0000100,
		ST_FLUSH = 7'b0001000,
		ST_BLANK = 7'b0010000,
		ST_READ  = 7'b0100000,
		ST_RESP  = 7'b1000000
	} st_t;

	st_t               state_q;
	logic              init_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [AW-1:0]     pos_q;
	logic [ATTR_W-1:0] attr_q;
	logic [AW-1:0]     a_q;
	logic [AW-1:0]     wa_q;
	logic              scroll_q;
	logic              pend_s1;
	logic [AW-1:0]     waddr_s1;
	cmd_t              cmd_q;
	logic [AW-1:0]     addr_q;

	logic              out_valid_q;
	logic [CELL_W-1:0] out_data_q;
	logic [COL_O_W-1:0] out_col_q;
	logic [ROW_O_W-1:0] out_row_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [CELL_W-1:0] rdata;
	logic              out_free;
	logic              load;
	logic [31:0]       col_ext;
	logic [31:0]       row_ext;

	tce_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign hold     = init_q;
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign out_free = !out_valid_q || res_ready;
	assign load     = (state_q == ST_RESP) && out_free;
	assign col_ext  = 32'(col_q);
	assign row_ext  = 32'(row_q);

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = {attr_q, SPACE_CODE};
		if (pend_s1) begin
			we    = 1'b1;
			waddr = waddr_s1;
			wdata = scroll_q ? rdata : {attr_q, rdata[CHAR_W-1:0]};
		end else if (state_q == ST_PUT) begin
			we    = 1'b1;
			wdata = {attr_q, cmd_q.newline ? SPACE_CODE : cmd_q.ch};
		end else if (state_q == ST_BLANK) begin
			we    = 1'b1;
			waddr = wa_q;
		end
	end

	assign re    = (state_q == ST_COPY) || (state_q == ST_READ);
	assign raddr = (state_q == ST_COPY) ? a_q : addr_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q  <= cmd;
			addr_q <= cmd_addr;
		end
		if (state_q == ST_COPY) begin
			waddr_s1 <= a_q - (scroll_q ? ROW_OFS : '0);
		end
		if (load) begin
			out_data_q <= (cmd_q.op == OP_READ && !cmd_q.oob) ? rdata : '0;
			out_col_q  <= col_ext[COL_O_W-1:0];
			out_row_q  <= row_ext[ROW_O_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BLANK;
			init_q      <= 1'b1;
			col_q       <= '0;
			row_q       <= '0;
			pos_q       <= '0;
			attr_q      <= RESET_ATTR;
			a_q         <= '0;
			wa_q        <= '0;
			scroll_q    <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_COPY);
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.op)
							OP_PUT: begin
								state_q <= ST_PUT;
							end
							OP_COLOR: begin
								attr_q   <= cmd.attr;
								a_q      <= '0;
								scroll_q <= 1'b0;
								state_q  <= ST_COPY;
							end
							OP_CLEAR: begin
								wa_q    <= '0;
								state_q <= ST_BLANK;
							end
							OP_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PUT: begin
					col_q <= col_q + 1'b1;
					pos_q <= pos_q + 1'b1;
					if (col_q == COL_LAST) begin
						col_q <= '0;
						if (row_q == ROW_LAST) begin
							pos_q    <= BOTTOM;
							a_q      <= ROW_OFS;
							scroll_q <= 1'b1;
							state_q  <= ST_COPY;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_RESP;
						end
					end else if (!cmd_q.newline) begin
						state_q <= ST_RESP;
					end
				end
				ST_COPY: begin
					a_q <= a_q + 1'b1;
					if (a_q == LAST_A) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (scroll_q) begin
						wa_q    <= BOTTOM;
						state_q <= ST_BLANK;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_BLANK: begin
					wa_q <= wa_q + 1'b1;
					if (wa_q == LAST_A) begin
						if (init_q) begin
							init_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_data_q;
	assign res_col   = out_col_q;
	assign res_row   = out_row_q;

`ifndef ASSERT_OFF
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_ext < COLUMNS)
		else $error("cursor column out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_ext < ROWS)
		else $error("cursor row out of range");

	a_pos_track: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (32'(pos_q) == row_ext * COLUMNS + col_ext))
		else $error("linear cursor address out of step with row and column");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !(state_q == ST_PUT || state_q == ST_BLANK))
		else $error("copy write collides with another cell write");

	a_no_pop_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !cmd_pop)
		else $error("command taken during the clearing pass");
`endif

endmodule

// File: tb/tb_text_mode_console_engine.sv
`timescale 1ns / 1ps

module tb_text_mode_console_engine;
	import tce_pkg::*;

	localparam int ROWS         = ROWS_DEF;
	localparam int COLUMNS      = COLUMNS_DEF;
	localparam int CELLS        = ROWS * COLUMNS;
	localparam int RANDOM_ITEMS = 300;
	localparam int DRAIN_CYCLES = 2 * CELLS + COLUMNS + 16;
	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [CELL_W-1:0]  data;
		logic [COL_O_W-1:0] col;
		logic [ROW_O_W-1:0] row;
	} reply_t;

	class console_scoreboard;
		logic [CELL_W-1:0] grid [CELLS];
		int unsigned       col;
		int unsigned       row;
		logic [ATTR_W-1:0] attr;
		reply_t            replies [$];
		int unsigned       errors;

		function new();
			foreach (grid[i]) grid[i] = {RESET_ATTR, SPACE_CODE};
			col    = 0;
			row    = 0;
			attr   = RESET_ATTR;
			errors = 0;
		endfunction

		function void note_request(op_t op, logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] fg,
				logic [COLOR_W-1:0] bg, logic [IDX_W-1:0] idx);
			reply_t r;
			r.data = '0;
			case (op)
				OP_PUT: begin
					if (ch == NEWLINE_CODE) begin
						while (col < COLUMNS) begin
							grid[row * COLUMNS + col] = {attr, SPACE_CODE};
							col++;
						end
					end else begin
						grid[row * COLUMNS + col] = {attr, ch};
						col++;
					end
					if (col >= COLUMNS) begin
						col = 0;
						row++;
						if (row >= ROWS) begin
							row = ROWS - 1;
							for (int i = 0; i < CELLS - COLUMNS; i++) grid[i] = grid[i + COLUMNS];
							for (int i = CELLS - COLUMNS; i < CELLS; i++) grid[i] = {attr, SPACE_CODE};
						end
					end
				end
				OP_COLOR: begin
					attr = {bg, fg};
					foreach (grid[i]) grid[i] = {attr, grid[i][CHAR_W-1:0]};
				end
				OP_CLEAR: begin
					foreach (grid[i]) grid[i] = {attr, SPACE_CODE};
				end
				OP_READ: begin
					if (idx < CELLS) r.data = grid[idx];
				end
				default: ;
			endcase
			r.col = col[COL_O_W-1:0];
			r.row = row[ROW_O_W-1:0];
			replies.push_back(r);
		endfunction

		function void check_response(logic [M_TDATA_W-1:0] tdata);
			reply_t want;
			reply_t got;
			got.data = tdata[RD_LSB +: CELL_W];
			got.col  = tdata[COL_LSB +: COL_O_W];
			got.row  = tdata[ROW_LSB +: ROW_O_W];
			if (replies.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected transfer: data=%h col=%0d row=%0d",
						got.data, got.col, got.row);
				return;
			end
			want = replies.pop_front();
			if (got.data !== want.data || got.col !== want.col || got.row !== want.row) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("mismatch: data exp %h got %h, col exp %0d got %0d, row exp %0d got %0d",
						want.data, got.data, want.col, got.col, want.row, got.row);
			end
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	int                   src_idle_pct   = 0;
	int                   sink_stall_pct = 0;
	int unsigned          cycles         = 0;
	int unsigned          issued         = 0;
	console_scoreboard    board;

	text_mode_console_engine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_response(m_tdata);
	end

	task automatic issue(op_t op, logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] fg,
			logic [COLOR_W-1:0] bg, logic [IDX_W-1:0] idx);
		logic [S_TDATA_W-1:0] word;
		word = '0;
		word[CH_LSB +: CHAR_W]   = ch;
		word[FG_LSB +: COLOR_W]  = fg;
		word[BG_LSB +: COLOR_W]  = bg;
		word[IDX_LSB +: IDX_W]   = idx;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		board.note_request(op, ch, fg, bg, idx);
		issued++;
	endtask

	initial begin
		int unsigned       base;
		int unsigned       pick;
		int unsigned       len;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;

		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		issue(OP_READ,  8'h00, 4'h0, 4'h0, 11'd0);
		issue(OP_READ,  8'h00, 4'h0, 4'h0, 11'(CELLS - 1));
		issue(OP_READ,  8'h00, 4'h0, 4'h0, 11'(CELLS));
		issue(OP_READ,  8'hFF, 4'hF, 4'hF, 11'h7FF);
		issue(OP_PUT,   8'h00, 4'h0, 4'h0, 11'd0);
		issue(OP_PUT,   8'hFF, 4'hF, 4'hF, 11'h7FF);
		issue(OP_PUT,   8'h41, 4'h3, 4'hC, 11'd5);
		issue(OP_PUT,   NEWLINE_CODE, 4'h0, 4'h0, 11'd0);
		issue(OP_READ,  8'h00, 4'h0, 4'h0, 11'd3);
		issue(OP_COLOR, 8'h00, 4'hF, 4'hF, 11'd0);
		issue(OP_READ,  8'h00, 4'h0, 4'h0, 11'd1);
		issue(OP_COLOR, 8'hFF, 4'h0, 4'h0, 11'h7FF);
		issue(OP_PUT,   8'h7E, 4'h0, 4'h0, 11'd0);
		issue(OP_COLOR, 8'h00, 4'hA, 4'h5, 11'd0);
		issue(OP_READ,  8'h00, 4'h0, 4'h0, 11'd80);
		issue(OP_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0);
		issue(OP_READ,  8'h00, 4'h0, 4'h0, 11'd80);
		issue(OP_PUT,   NEWLINE_CODE, 4'h0, 4'h0, 11'd0);
		issue(OP_PUT,   NEWLINE_CODE, 4'h0, 4'h0, 11'd0);
		issue(OP_PUT,   8'h80, 4'h0, 4'h0, 11'd0);
		issue(OP_PUT,   8'h7F, 4'h0, 4'h0, 11'd0);
		issue(OP_READ,  8'h00, 4'h0, 4'h0, 11'd1023);
		issue(OP_READ,  8'h00, 4'h0, 4'h0, 11'd1024);
		issue(OP_READ,  8'h00, 4'h0, 4'h0, 11'(CELLS - 1));

		base = issued;
		while (issued - base < RANDOM_ITEMS) begin
			case ((issued - base) * 4 / RANDOM_ITEMS)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 85;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 85;
				end
				default: begin
					src_idle_pct   = 10;
					sink_stall_pct = 10;
				end
			endcase
			pick = $urandom_range(0, 99);
			len  = $urandom_range(1, 4);
			if (pick < 8) begin
				len = $urandom_range(40, 90);
				repeat (len) begin
					do ch = 8'($urandom); while (ch == NEWLINE_CODE);
					issue(OP_PUT, ch, 4'($urandom), 4'($urandom), 11'($urandom));
				end
			end else if (pick < 40) begin
				repeat (len)
					issue(OP_PUT, NEWLINE_CODE, 4'($urandom), 4'($urandom), 11'($urandom));
			end else if (pick < 72) begin
				repeat (len) begin
					if ($urandom_range(0, 1) == 0)
						idx = 11'($urandom);
					else
						idx = 11'(board.row * COLUMNS + $urandom_range(0, COLUMNS - 1));
					issue(OP_READ, 8'($urandom), 4'($urandom), 4'($urandom), idx);
				end
			end else if (pick < 78) begin
				issue(OP_COLOR, 8'($urandom), 4'($urandom), 4'($urandom), 11'($urandom));
			end else if (pick < 84) begin
				issue(OP_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom), 11'($urandom));
			end else begin
				repeat (2 * len)
					issue(OP_PUT, 8'($urandom), 4'($urandom), 4'($urandom), 11'($urandom));
			end
		end
		s_tvalid <= 1'b0;

		while (board.replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.replies.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
